[hw/rtl/mft_pkg.sv]
// Shared types and constants for the Manchester frame transmitter.
`default_nettype none
package mft_pkg;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CountW   = 3;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned BitIdxW  = 3;

    localparam logic [CfgIdxW-1:0] CFG_PREAMBLE_COUNT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PREAMBLE_VALUE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_VALUE     = 2'd2;

    localparam logic [CountW-1:0] PREAMBLE_COUNT_RST = 3'd4;
    localparam logic [CountW-1:0] PREAMBLE_MAX       = 3'd5;
    localparam logic [ByteW-1:0]  PREAMBLE_VALUE_RST = 8'hFF;
    localparam logic [ByteW-1:0]  SYNC_VALUE_RST     = 8'h7F;
    localparam logic [BitIdxW-1:0] LAST_BIT          = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PRE   = 5'b00010,
        ST_SYNC  = 5'b00100,
        ST_DATA  = 5'b01000,
        ST_TRAIL = 5'b10000
    } t_state;

    typedef struct packed {
        logic first_half;
        logic second_half;
        logic half_only;
        logic run_end;
    } t_cell;

    typedef struct packed {
        logic [CountW-1:0] preamble_count;
        logic [ByteW-1:0]  preamble_value;
        logic [ByteW-1:0]  sync_value;
    } t_cfg;

endpackage
`default_nettype wire

[hw/rtl/mft_ctrl.sv]
// Frame sequencer and bit serialiser: one Manchester cell per cycle while the output is free.
`default_nettype none
module mft_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mft_pkg::t_cfg               i_cfg,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [mft_pkg::ByteW-1:0]   i_data_byte,
    input  wire logic                        i_first_of_frame,
    input  wire logic                        i_last_of_frame,
    input  wire logic                        i_out_free,
    output logic                             o_cell_load,
    output mft_pkg::t_cell                   o_cell
);
    import mft_pkg::*;

    t_state             r_state, n_state;
    logic [ByteW-1:0]   r_shift, n_shift;
    logic [ByteW-1:0]   r_data, n_data;
    logic               r_last, n_last;
    logic [BitIdxW-1:0] r_bitcnt, n_bitcnt;
    logic [CountW-1:0]  r_precnt, n_precnt;
    logic [CountW-1:0]  pre_cnt;
    logic               accept;
    logic               adv;
    logic               byte_done;

    // counts of six and seven behave as five
    assign pre_cnt    = (i_cfg.preamble_count > PREAMBLE_MAX) ? PREAMBLE_MAX
                                                              : i_cfg.preamble_count;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign adv        = (r_state != ST_IDLE) && i_out_free;
    assign byte_done  = (r_bitcnt == LAST_BIT);
    assign o_cell_load = adv;

    always_comb begin
        o_cell = '0;
        if (r_state == ST_TRAIL) begin
            o_cell.first_half  = r_data[ByteW-1];
            o_cell.second_half = 1'b1;
            o_cell.half_only   = 1'b1;
            o_cell.run_end     = 1'b1;
        end else begin
            o_cell.first_half  = r_shift[0];
            o_cell.second_half = ~r_shift[0];
            o_cell.half_only   = 1'b0;
            o_cell.run_end     = (r_state == ST_DATA) && byte_done && !r_last;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_shift  = r_shift;
        n_data   = r_data;
        n_last   = r_last;
        n_bitcnt = r_bitcnt;
        n_precnt = r_precnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_data   = i_data_byte;
                    n_last   = i_last_of_frame;
                    n_bitcnt = '0;
                    if (i_first_of_frame && (pre_cnt != '0)) begin
                        n_state  = ST_PRE;
                        n_shift  = i_cfg.preamble_value;
                        n_precnt = pre_cnt - 1'b1;
                    end else if (i_first_of_frame) begin
                        n_state = ST_SYNC;
                        n_shift = i_cfg.sync_value;
                    end else begin
                        n_state = ST_DATA;
                        n_shift = i_data_byte;
                    end
                end
            end
            ST_PRE, ST_SYNC, ST_DATA: begin
                if (adv) begin
                    n_shift  = {1'b0, r_shift[ByteW-1:1]};
                    n_bitcnt = r_bitcnt + 1'b1;
                    if (byte_done) begin
                        case (r_state)
                            ST_PRE: begin
                                if (r_precnt == '0) begin
                                    n_state = ST_SYNC;
                                    n_shift = i_cfg.sync_value;
                                end else begin
                                    n_shift  = i_cfg.preamble_value;
                                    n_precnt = r_precnt - 1'b1;
                                end
                            end
                            ST_SYNC: begin
                                n_state = ST_DATA;
                                n_shift = r_data;
                            end
                            default: begin
                                n_state = r_last ? ST_TRAIL : ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_TRAIL: begin
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_shift  <= n_shift;
        r_data   <= n_data;
        r_last   <= n_last;
        r_bitcnt <= n_bitcnt;
        r_precnt <= n_precnt;
    end

endmodule
`default_nettype wire

[hw/rtl/mft_obuf.sv]
// Output register holding one cell beat until the receiver takes it.
`default_nettype none
module mft_obuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire mft_pkg::t_cell i_cell,
    output logic                o_free,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mft_pkg::t_cell      o_cell
);
    import mft_pkg::*;

    logic  r_valid;
    t_cell r_cell;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_cell <= i_cell;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/manchester_frame_transmitter_top.sv]
// Manchester frame transmitter: top level with configuration registers.
//
// Input channel (i_in_valid/o_in_ready) takes one frame byte per beat with
// first/last marks. Output channel (o_out_valid/i_out_ready) gives one
// Manchester cell per beat, LSB first; a one is high-low, a zero low-high.
// A first byte is preceded by preamble_count fill bytes (6 and 7 act as 5)
// and the sync byte; a last byte is followed by a half-bit trailer cell.
// run_end flags the final cell of each input byte.
// Cells per byte: 8, plus 8*(count+1) on a first byte, plus 1 on a last.
// First cell passes through the shift register and the output register before
// it is visible; cells then leave one per cycle from the shift register while
// the receiver keeps taking them. o_in_ready rises again in the same cycle as
// the final cell is registered into the output register.
// A stalled receiver holds the output register and freezes the serialiser;
// nothing is dropped. Reset empties the output, returns the sequencer to
// idle and loads count 4, fill 0xFF, sync 0x7F. Configuration writes
// (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; index 3 is ignored.
`default_nettype none
module manchester_frame_transmitter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mft_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [mft_pkg::ByteW-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mft_pkg::ByteW-1:0]     i_data_byte,
    input  wire logic                          i_first_of_frame,
    input  wire logic                          i_last_of_frame,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_first_half,
    output logic                               o_second_half,
    output logic                               o_half_only,
    output logic                               o_run_end
);
    import mft_pkg::*;

    t_cfg  r_cfg;
    t_cell ctrl_cell;
    t_cell out_cell;
    logic  cell_load;
    logic  out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_count <= PREAMBLE_COUNT_RST;
            r_cfg.preamble_value <= PREAMBLE_VALUE_RST;
            r_cfg.sync_value     <= SYNC_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREAMBLE_COUNT: r_cfg.preamble_count <= i_cfg_data[CountW-1:0];
                CFG_PREAMBLE_VALUE: r_cfg.preamble_value <= i_cfg_data;
                CFG_SYNC_VALUE:     r_cfg.sync_value     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mft_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_last_of_frame  (i_last_of_frame),
        .i_out_free       (out_free),
        .o_cell_load      (cell_load),
        .o_cell           (ctrl_cell)
    );

    mft_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cell_load),
        .i_cell  (ctrl_cell),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_cell  (out_cell)
    );

    assign o_first_half  = out_cell.first_half;
    assign o_second_half = out_cell.second_half;
    assign o_half_only   = out_cell.half_only;
    assign o_run_end     = out_cell.run_end;

endmodule
`default_nettype wire

[tb/sv/manchester_frame_transmitter_top_tb.sv]
// Self-checking testbench for the Manchester frame transmitter top level.
`default_nettype none
module manchester_frame_transmitter_top_tb;
    import mft_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned LitW = 57;
    localparam int unsigned NumPhases = 9;
    localparam int unsigned ItemsPerPhase = 54;

    typedef enum logic {ROW_CFG, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CfgIdxW-1:0] idx;
        logic [ByteW-1:0]   val;
        logic [ByteW-1:0]   data;
        logic               first;
        logic               last;
        int                 lit_n;      // 0: expectation comes from the predictor
        logic [LitW-1:0]    lit_bits;   // cell bits in line order, bit 0 sent first
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [ByteW-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [ByteW-1:0] i_data_byte = '0;
    logic             i_first_of_frame = 1'b0;
    logic             i_last_of_frame = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_first_half;
    logic             o_second_half;
    logic             o_half_only;
    logic             o_run_end;

    manchester_frame_transmitter_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_last_of_frame  (i_last_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_first_half     (o_first_half),
        .o_second_half    (o_second_half),
        .o_half_only      (o_half_only),
        .o_run_end        (o_run_end)
    );

    // shadow of the block: configuration and cells still owed
    t_cfg  cfg_shadow;
    t_cell tx_cells_q[$];
    t_cell mon_want;

    t_row  dir_tab[$];
    int    send_idle_pct = 34;
    int    recv_idle_pct = 86;
    int    err_cnt = 0;
    int    n_bytes = 0;
    int    n_first = 0;
    int    n_cells = 0;
    int    n_cfg = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("manchester_frame_transmitter_top_tb: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_cells++;
            if (tx_cells_q.size() == 0) begin
                flag_mismatch("cell beat with nothing expected");
            end else begin
                mon_want = tx_cells_q.pop_front();
                if (o_first_half !== mon_want.first_half)
                    flag_mismatch($sformatf("first_half got %b want %b",
                                            o_first_half, mon_want.first_half));
                if (o_second_half !== mon_want.second_half)
                    flag_mismatch($sformatf("second_half got %b want %b",
                                            o_second_half, mon_want.second_half));
                if (o_half_only !== mon_want.half_only)
                    flag_mismatch($sformatf("half_only got %b want %b",
                                            o_half_only, mon_want.half_only));
                if (o_run_end !== mon_want.run_end)
                    flag_mismatch($sformatf("run_end got %b want %b",
                                            o_run_end, mon_want.run_end));
            end
        end
    end

    function automatic void push_cell(input logic a, input logic b, input logic half,
                                      input logic fin);
        t_cell c;
        c.first_half  = a;
        c.second_half = b;
        c.half_only   = half;
        c.run_end     = fin;
        tx_cells_q.push_back(c);
    endfunction

    function automatic void push_byte_cells(input logic [ByteW-1:0] v, input logic fin);
        for (int k = 0; k < ByteW; k++)
            push_cell(v[k], ~v[k], 1'b0, fin && (k == ByteW - 1));
    endfunction

    function automatic void predict_cells(input logic [ByteW-1:0] d, input logic f,
                                          input logic l);
        logic [CountW-1:0] cnt;
        cnt = cfg_shadow.preamble_count;
        if (f) begin
            if (cnt > PREAMBLE_MAX) cnt = PREAMBLE_MAX;
            for (int i = 0; i < cnt; i++) push_byte_cells(cfg_shadow.preamble_value, 1'b0);
            push_byte_cells(cfg_shadow.sync_value, 1'b0);
        end
        push_byte_cells(d, ~l);
        // trailer half cell, line then rests high
        if (l) push_cell(d[ByteW-1], 1'b1, 1'b1, 1'b1);
    endfunction

    function automatic void push_literal(input int n, input logic [LitW-1:0] bits,
                                         input logic l);
        for (int k = 0; k < n; k++) begin
            if (l && k == n - 1) push_cell(bits[k], 1'b1, 1'b1, 1'b1);
            else                 push_cell(bits[k], ~bits[k], 1'b0, k == n - 1);
        end
    endfunction

    function automatic void row_cfg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] v);
        t_row r;
        r = '{ROW_CFG, idx, v, '0, 1'b0, 1'b0, 0, '0};
        dir_tab.push_back(r);
    endfunction

    function automatic void row_byte(input logic [ByteW-1:0] d, input logic f, input logic l,
                                     input int n, input logic [LitW-1:0] bits);
        t_row r;
        r = '{ROW_BYTE, '0, '0, d, f, l, n, bits};
        dir_tab.push_back(r);
    endfunction

    task automatic wait_drained();
        while (tx_cells_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] v);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_PREAMBLE_COUNT: cfg_shadow.preamble_count = v[CountW-1:0];
            CFG_PREAMBLE_VALUE: cfg_shadow.preamble_value = v;
            CFG_SYNC_VALUE:     cfg_shadow.sync_value     = v;
            default: ;
        endcase
        n_cfg++;
    endtask

    // returns at the edge the beat is taken, valid still high
    task automatic send_byte(input logic [ByteW-1:0] d, input logic f, input logic l,
                             input int lit_n, input logic [LitW-1:0] lit_bits);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= d;
        i_first_of_frame <= f;
        i_last_of_frame  <= l;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (lit_n != 0) push_literal(lit_n, lit_bits, l);
        else            predict_cells(d, f, l);
        n_bytes++;
        if (f) n_first++;
    endtask

    initial begin
        int sent;
        int flen;
        logic f;
        logic l;
        logic [CountW-1:0] cnt;
        logic [ByteW-1:0] fill;
        logic [ByteW-1:0] sync;

        cfg_shadow.preamble_count = PREAMBLE_COUNT_RST;
        cfg_shadow.preamble_value = PREAMBLE_VALUE_RST;
        cfg_shadow.sync_value     = SYNC_VALUE_RST;

        // reset settings: four fill bytes of 0xFF, sync 0x7F
        row_byte(8'h00, 1'b0, 1'b0, 8,  57'h0);
        row_byte(8'hFF, 1'b0, 1'b0, 8,  57'hFF);
        row_byte(8'hA5, 1'b1, 1'b0, 48, LitW'({8'hA5, 8'h7F, 32'hFFFF_FFFF}));
        row_byte(8'h80, 1'b0, 1'b1, 9,  LitW'({1'b1, 8'h80}));
        row_byte(8'h7F, 1'b0, 1'b1, 9,  LitW'({1'b0, 8'h7F}));
        row_byte(8'h3C, 1'b1, 1'b1, 49, LitW'({1'b0, 8'h3C, 8'h7F, 32'hFFFF_FFFF}));
        // unused register index must change nothing
        row_cfg(CFG_UNUSED, 8'h00);
        row_byte(8'h01, 1'b1, 1'b0, 48, LitW'({8'h01, 8'h7F, 32'hFFFF_FFFF}));
        row_cfg(CFG_PREAMBLE_COUNT, 8'h00);
        row_byte(8'hC3, 1'b1, 1'b0, 16, LitW'({8'hC3, 8'h7F}));
        // count 7 behaves as 5: longest run of cells
        row_cfg(CFG_PREAMBLE_COUNT, 8'hFF);
        row_cfg(CFG_PREAMBLE_VALUE, 8'h00);
        row_cfg(CFG_SYNC_VALUE, 8'h00);
        row_byte(8'hFF, 1'b1, 1'b1, 57, {1'b1, 8'hFF, 8'h00, 40'h0});
        row_cfg(CFG_PREAMBLE_COUNT, 8'h06);
        row_cfg(CFG_PREAMBLE_VALUE, 8'h55);
        row_cfg(CFG_SYNC_VALUE, 8'hAA);
        row_byte(8'h5A, 1'b1, 1'b0, 0, '0);
        row_byte(8'h96, 1'b0, 1'b1, 0, '0);
        row_cfg(CFG_PREAMBLE_COUNT, 8'h05);
        row_byte(8'h00, 1'b1, 1'b1, 0, '0);
        row_byte(8'h69, 1'b0, 1'b0, 0, '0);
        row_byte(8'hE1, 1'b1, 1'b0, 0, '0);
        row_byte(8'h1E, 1'b1, 1'b0, 0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_cfg(dir_tab[i].idx, dir_tab[i].val);
            else
                send_byte(dir_tab[i].data, dir_tab[i].first, dir_tab[i].last,
                          dir_tab[i].lit_n, dir_tab[i].lit_bits);
        end

        for (int p = 0; p < NumPhases; p++) begin
            case (p / 3)
                0: begin send_idle_pct = 34; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (p % 3)
                0: begin cnt = 3'd0; fill = 8'h00; sync = 8'hFF; end
                1: begin cnt = PREAMBLE_MAX; fill = 8'hFF; sync = 8'h00; end
                default: begin
                    cnt = 3'($urandom_range(7));
                    fill = 8'($urandom_range(255));
                    sync = 8'($urandom_range(255));
                end
            endcase
            if (p == 4) cnt = 3'd7;
            if (p == 7) cnt = 3'd6;
            // upper data bits are don't-care for the count register
            write_cfg(CFG_PREAMBLE_COUNT, {5'($urandom_range(31)), cnt});
            write_cfg(CFG_PREAMBLE_VALUE, fill);
            write_cfg(CFG_SYNC_VALUE, sync);
            if ($urandom_range(3) == 0) write_cfg(CFG_UNUSED, 8'($urandom_range(255)));

            sent = 0;
            while (sent < ItemsPerPhase) begin
                if ($urandom_range(99) < 20) begin
                    // stray byte with arbitrary marks
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 0, '0);
                    sent++;
                end else begin
                    flen = $urandom_range(1, 6);
                    for (int k = 0; k < flen; k++) begin
                        f = (k == 0);
                        l = (k == flen - 1);
                        send_byte(8'($urandom_range(255)), f, l, 0, '0);
                        sent++;
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        while (tx_cells_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes (%0d frame starts), checked %0d cells, %0d register writes.",
                 n_bytes, n_first, n_cells, n_cfg);
        $display("Preamble counts 0 to 7, fill and sync extremes, three idle patterns.");
        if (err_cnt == 0) begin
            $display("manchester_frame_transmitter_top_tb: clean");
        end else begin
            $display("manchester_frame_transmitter_top_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/mft_pkg.sv
hw/rtl/mft_ctrl.sv
hw/rtl/mft_obuf.sv
hw/rtl/manchester_frame_transmitter_top.sv
tb/sv/manchester_frame_transmitter_top_tb.sv
